// File: src/min_contiguous_rb_allocation_finder_macros.svh
// Assertion macros shared by the finder RTL
`ifndef MIN_CONTIGUOUS_RB_ALLOCATION_FINDER_MACROS_SVH
`define MIN_CONTIGUOUS_RB_ALLOCATION_FINDER_MACROS_SVH

// same-cycle implication
`define MCRB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("implication check failed");

// next-cycle implication
`define MCRB_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// File: src/mcrb_pkg.sv
package mcrb_pkg;

	localparam int NUM_BLOCKS   = 32;
	localparam int RATE_CEILING = 65535;

	localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

	localparam int RATE_W  = 16;
	localparam int REQ_W   = 21;
	localparam int BLK_W   = 5;
	localparam int BCNT_W  = 6;
	localparam int PROD_W  = RATE_W + CNT_W;

	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_idx;
		logic             rotate;
		logic             load;
		logic             shift;
	} mcrb_ctl_t;

endpackage

// File: src/mcrb_cell.sv
module mcrb_cell
	import mcrb_pkg::*;
(
	input  logic              clk,
	input  logic              wr_en,
	input  logic [RATE_W-1:0] wr_rate,
	input  logic              rotate,
	input  logic              load,
	input  logic              shift,
	input  logic [RATE_W-1:0] base_nxt,
	input  logic [RATE_W-1:0] scan_nxt,
	output logic [RATE_W-1:0] base,
	output logic [RATE_W-1:0] scan
);

	logic [RATE_W-1:0] base_q;
	logic [RATE_W-1:0] scan_q;

	// base ring: written in place while loading, rotated one step per start and per realign step
	always_ff @(posedge clk) begin
		if (wr_en) begin
			base_q <= wr_rate;
		end else if (rotate) begin
			base_q <= base_nxt;
		end
	end

	// scan chain: copy of the ring from the current start, shifted once per step
	always_ff @(posedge clk) begin
		if (load) begin
			scan_q <= base_nxt;
		end else if (shift) begin
			scan_q <= scan_nxt;
		end
	end

	assign base = base_q;
	assign scan = scan_q;

endmodule

// File: src/mcrb_chain.sv
module mcrb_chain
	import mcrb_pkg::*;
(
	input  logic              clk,
	input  mcrb_ctl_t         ctl,
	input  logic [RATE_W-1:0] wr_rate,
	output logic [RATE_W-1:0] head_base,
	output logic [RATE_W-1:0] head_scan
);

	logic [RATE_W-1:0] base_w [NUM_BLOCKS];
	logic [RATE_W-1:0] scan_w [NUM_BLOCKS];

	for (genvar i = 0; i < NUM_BLOCKS; i++) begin : g_cell
		localparam int NXT = (i + 1) % NUM_BLOCKS;

		mcrb_cell u_cell (
			.clk      (clk),
			.wr_en    (ctl.wr_en && (ctl.wr_idx == IDX_W'(i))),
			.wr_rate  (wr_rate),
			.rotate   (ctl.rotate),
			.load     (ctl.load),
			.shift    (ctl.shift),
			.base_nxt (base_w[NXT]),
			.scan_nxt (scan_w[NXT]),
			.base     (base_w[i]),
			.scan     (scan_w[i])
		);
	end

	assign head_base = base_w[0];
	assign head_scan = scan_w[0];

endmodule

// File: src/min_contiguous_rb_allocation_finder.sv
// channel   dir  handshake                   payload
// item      in   start & !busy               rb_rate, required_rate, last_block
// result    out  result_strobe, one cycle    valid_res, start_block, end_block,
//                                            achieved_rate, block_count, last_result
//
// Loading writes each item into the next cell, up to NUM_BLOCKS cells. After the
// item marked last_block the block is busy: it takes one scan step of the cell
// chain per start/end pair tried (at most n(n+1)/2), flushes the final result,
// then rotates the ring back to cell 0 in the realign state if n < NUM_BLOCKS.
// Reset clears control state and the result strobe; cell contents are not reset.
// Results cannot be stalled; each is held for exactly one cycle.
`include "min_contiguous_rb_allocation_finder_macros.svh"

module min_contiguous_rb_allocation_finder
	import mcrb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [RATE_W-1:0] rb_rate,
	input  logic [REQ_W-1:0]  required_rate,
	input  logic              last_block,
	output logic              result_strobe,
	output logic              valid_res,
	output logic [BLK_W-1:0]  start_block,
	output logic [BLK_W-1:0]  end_block,
	output logic [REQ_W-1:0]  achieved_rate,
	output logic [BCNT_W-1:0] block_count,
	output logic              last_result
);

	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_SCAN    = 2'd1;
	localparam logic [1:0] ST_FLUSH   = 2'd2;
	localparam logic [1:0] ST_REALIGN = 2'd3;

	logic [1:0]        state_q;
	logic [CNT_W-1:0]  loaded_q;
	logic [CNT_W-1:0]  scan_n_q;
	logic [REQ_W-1:0]  target_q;
	logic [IDX_W-1:0]  j_q;
	logic [IDX_W-1:0]  k_q;
	logic              first_q;
	logic [RATE_W-1:0] mn_q;

	logic              pend_v_q;
	logic [IDX_W-1:0]  pend_s_q;
	logic [IDX_W-1:0]  pend_e_q;
	logic [REQ_W-1:0]  pend_rate_q;
	logic [CNT_W-1:0]  pend_cnt_q;

	logic              result_strobe_q;
	logic              valid_res_q;
	logic [BLK_W-1:0]  start_block_q;
	logic [BLK_W-1:0]  end_block_q;
	logic [REQ_W-1:0]  achieved_rate_q;
	logic [BCNT_W-1:0] block_count_q;
	logic              last_result_q;

	mcrb_ctl_t         ctl;
	logic [RATE_W-1:0] head_base;
	logic [RATE_W-1:0] head_scan;
	logic [RATE_W-1:0] cur_rate;
	logic [RATE_W-1:0] mn_base;
	logic [RATE_W-1:0] mn_new;
	logic [CNT_W-1:0]  run_len;
	logic [PROD_W-1:0] got;
	logic              hit;
	logic              end_of_run;
	logic              accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	mcrb_chain u_chain (
		.clk       (clk),
		.ctl       (ctl),
		.wr_rate   (rb_rate),
		.head_base (head_base),
		.head_scan (head_scan)
	);

	// one scan step: fold the next rate into the running minimum and test the run
	assign cur_rate   = first_q ? head_base : head_scan;
	assign mn_base    = first_q ? RATE_W'(RATE_CEILING) : mn_q;
	assign mn_new     = (cur_rate < mn_base) ? cur_rate : mn_base;
	assign run_len    = CNT_W'(k_q) - CNT_W'(j_q) + CNT_W'(1);
	assign got        = PROD_W'(mn_new) * PROD_W'(run_len);
	assign hit        = (got >= PROD_W'(target_q));
	assign end_of_run = (CNT_W'(k_q) == scan_n_q - CNT_W'(1));

	always_comb begin
		ctl        = '0;
		ctl.wr_idx = loaded_q[IDX_W-1:0];
		case (state_q)
			ST_IDLE: begin
				ctl.wr_en = accept && (loaded_q < CNT_W'(NUM_BLOCKS));
			end
			ST_SCAN: begin
				ctl.rotate = first_q;
				ctl.load   = first_q;
				ctl.shift  = !first_q;
			end
			ST_REALIGN: begin
				ctl.rotate = 1'b1;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			loaded_q        <= '0;
			scan_n_q        <= '0;
			target_q        <= '0;
			j_q             <= '0;
			k_q             <= '0;
			first_q         <= 1'b0;
			mn_q            <= '0;
			pend_v_q        <= 1'b0;
			result_strobe_q <= 1'b0;
		end else begin
			result_strobe_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (last_block) begin
							target_q <= required_rate;
							scan_n_q <= (loaded_q < CNT_W'(NUM_BLOCKS)) ?
								loaded_q + CNT_W'(1) : loaded_q;
							loaded_q <= '0;
							j_q      <= '0;
							k_q      <= '0;
							first_q  <= 1'b1;
							pend_v_q <= 1'b0;
							state_q  <= ST_SCAN;
						end else if (loaded_q < CNT_W'(NUM_BLOCKS)) begin
							loaded_q <= loaded_q + CNT_W'(1);
						end
					end
				end
				ST_SCAN: begin
					mn_q <= mn_new;
					if (hit) begin
						if (pend_v_q) begin
							result_strobe_q <= 1'b1;
						end
						pend_v_q <= 1'b1;
					end
					if (hit || end_of_run) begin
						first_q <= 1'b1;
						if (CNT_W'(j_q) == scan_n_q - CNT_W'(1)) begin
							state_q <= ST_FLUSH;
						end else begin
							j_q <= j_q + IDX_W'(1);
							k_q <= j_q + IDX_W'(1);
						end
					end else begin
						first_q <= 1'b0;
						k_q     <= k_q + IDX_W'(1);
					end
				end
				ST_FLUSH: begin
					result_strobe_q <= 1'b1;
					pend_v_q        <= 1'b0;
					j_q             <= scan_n_q[IDX_W-1:0];
					state_q         <= (scan_n_q == CNT_W'(NUM_BLOCKS)) ? ST_IDLE : ST_REALIGN;
				end
				ST_REALIGN: begin
					j_q <= j_q + IDX_W'(1);
					if (CNT_W'(j_q) == CNT_W'(NUM_BLOCKS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// pending result: held until the next success or the end of the scan
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && hit) begin
			pend_s_q    <= j_q;
			pend_e_q    <= k_q;
			pend_rate_q <= REQ_W'(got);
			pend_cnt_q  <= run_len;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && hit && pend_v_q) begin
			valid_res_q     <= 1'b1;
			start_block_q   <= BLK_W'(pend_s_q);
			end_block_q     <= BLK_W'(pend_e_q);
			achieved_rate_q <= pend_rate_q;
			block_count_q   <= BCNT_W'(pend_cnt_q);
			last_result_q   <= 1'b0;
		end else if (state_q == ST_FLUSH) begin
			valid_res_q     <= pend_v_q;
			start_block_q   <= pend_v_q ? BLK_W'(pend_s_q) : '0;
			end_block_q     <= pend_v_q ? BLK_W'(pend_e_q) : '0;
			achieved_rate_q <= pend_v_q ? pend_rate_q : '0;
			block_count_q   <= pend_v_q ? BCNT_W'(pend_cnt_q) : '0;
			last_result_q   <= 1'b1;
		end
	end

	assign result_strobe = result_strobe_q;
	assign valid_res     = valid_res_q;
	assign start_block   = start_block_q;
	assign end_block     = end_block_q;
	assign achieved_rate = achieved_rate_q;
	assign block_count   = block_count_q;
	assign last_result   = last_result_q;

	`MCRB_ASSERT_NXT(a_flush_emits_last, clk, arst_n, state_q == ST_FLUSH,
		result_strobe_q && last_result_q)
	`MCRB_ASSERT_IMP(a_empty_result, clk, arst_n, result_strobe_q && !valid_res_q,
		last_result_q && (block_count_q == '0))
	`MCRB_ASSERT_IMP(a_scan_bounds, clk, arst_n, state_q == ST_SCAN,
		(k_q >= j_q) && (CNT_W'(k_q) < scan_n_q))
	`MCRB_ASSERT_IMP(a_rate_met, clk, arst_n, result_strobe_q && valid_res_q,
		achieved_rate_q >= target_q)

endmodule
